>>> hw/rtl/fmr_pkg.sv
// Package for the framed message receiver: frame parser phases, reply codes,
// field widths and the result record type. No dependencies.
`default_nettype none
package fmr_pkg;

  localparam int unsigned MAX_PAYLOAD = 63;
  localparam int unsigned SEQ_W       = 6;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned SUM_W       = 16;

  localparam logic [1:0] REPLY_ACK  = 2'b11;  // bits 7..6 of an ack byte
  localparam logic [1:0] REPLY_NACK = 2'b10;  // bits 7..6 of a nack byte

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  localparam logic RES_PAYLOAD = 1'b0;
  localparam logic RES_REPLY   = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SEQ     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_SUM_HI  = 3'd3,
    PH_SUM_LO  = 3'd4,
    PH_WAIT    = 3'd5
  } phase_t;

  typedef struct packed {
    logic              result_kind;
    logic [BYTE_W-1:0] data;
    logic              accepted;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

endpackage
`default_nettype wire

>>> hw/rtl/framed_message_receiver_top.sv
// Framed message receiver top level: frame parser, checksum, reply generation
// and a two-entry output register/skid stage. Depends on fmr_pkg.
`default_nettype none
// Receive side of a stop-and-wait serial link. Each input transfer is one
// received byte (in_kind = 0) or one inter-byte silence timeout (in_kind = 1).
// Frames are: length, sequence, payload, checksum high, checksum low, where
// the checksum is the 16-bit sum of each byte times its position (length byte
// is position 1). Payload bytes leave as they arrive; the first timeout after
// a frame ends or fails emits one ack/nack byte {1, ack, seq[5:0]}. An item is
// taken every cycle unless in_stall is high, and processed in that cycle by a
// single 7x8 multiply-add whose result is registered into the output or skid
// register. The input stalls only when both registers hold undelivered
// results. cfg_data sets buffer_limit (reset 63); it is always ready.
module framed_message_receiver_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_kind,
  input  wire logic [fmr_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_result_kind,
  output logic [fmr_pkg::BYTE_W-1:0]      out_data,
  output logic                            out_accepted,
  output logic [fmr_pkg::LEN_W-1:0]       out_frame_length,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [fmr_pkg::LEN_W-1:0]  cfg_data
);

  fmr_pkg::phase_t               phase_r, phase_nxt;
  logic [fmr_pkg::LEN_W-1:0]     limit_r;
  logic [fmr_pkg::SEQ_W-1:0]     exp_seq_r, exp_seq_nxt;
  logic [fmr_pkg::SEQ_W-1:0]     reply_seq_r, reply_seq_nxt;
  logic [fmr_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic [fmr_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [fmr_pkg::LEN_W-1:0]     frame_len_r, frame_len_nxt;
  logic [fmr_pkg::LEN_W-1:0]     left_r, left_nxt;
  logic                          good_r, good_nxt;

  logic                          in_xfer;
  logic                          res_vld;
  fmr_pkg::result_t              res;

  logic [fmr_pkg::POS_W-1:0]     pos_inc;
  logic [fmr_pkg::POS_W+fmr_pkg::BYTE_W-1:0] prod;
  logic [fmr_pkg::SUM_W-1:0]     sum_add;
  logic                          too_long;

  logic                          out_valid_r, skid_valid_r;
  fmr_pkg::result_t              out_r, skid_r;
  logic                          out_open;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_xfer   = in_valid && !in_stall;

  assign pos_inc  = pos_r + fmr_pkg::POS_W'(1);
  assign prod     = pos_inc * in_rx_byte;
  assign sum_add  = sum_r + fmr_pkg::SUM_W'(prod);
  assign too_long = (in_rx_byte > fmr_pkg::BYTE_W'(fmr_pkg::MAX_PAYLOAD)) ||
                    (in_rx_byte > {2'b00, limit_r});

  always_comb begin
    phase_nxt     = phase_r;
    exp_seq_nxt   = exp_seq_r;
    reply_seq_nxt = reply_seq_r;
    sum_nxt       = sum_r;
    pos_nxt       = pos_r;
    frame_len_nxt = frame_len_r;
    left_nxt      = left_r;
    good_nxt      = good_r;
    res_vld       = 1'b0;
    res           = '0;

    if (in_kind == fmr_pkg::KIND_TIMEOUT) begin
      if (phase_r == fmr_pkg::PH_WAIT) begin
        res_vld         = 1'b1;
        res.result_kind = fmr_pkg::RES_REPLY;
        if (good_r) begin
          res.data         = {fmr_pkg::REPLY_ACK, reply_seq_r};
          res.accepted     = 1'b1;
          res.frame_length = frame_len_r;
          exp_seq_nxt      = exp_seq_r + fmr_pkg::SEQ_W'(1);
        end else begin
          res.data = {fmr_pkg::REPLY_NACK, reply_seq_r};
        end
        phase_nxt = fmr_pkg::PH_IDLE;
        good_nxt  = 1'b0;
      end else if (phase_r inside {fmr_pkg::PH_SEQ, fmr_pkg::PH_PAYLOAD,
                                   fmr_pkg::PH_SUM_HI, fmr_pkg::PH_SUM_LO}) begin
        good_nxt  = 1'b0;
        phase_nxt = fmr_pkg::PH_WAIT;
      end else begin
        phase_nxt = fmr_pkg::PH_IDLE;
      end
    end else begin
      case (phase_r)
        fmr_pkg::PH_SEQ: begin
          if (in_rx_byte != {2'b00, exp_seq_r}) begin
            if (in_rx_byte[7:6] == 2'b00) exp_seq_nxt = in_rx_byte[5:0];
            good_nxt  = 1'b0;
            phase_nxt = fmr_pkg::PH_WAIT;
          end else begin
            pos_nxt   = pos_inc;
            sum_nxt   = sum_add;
            phase_nxt = (left_r == '0) ? fmr_pkg::PH_SUM_HI : fmr_pkg::PH_PAYLOAD;
          end
        end
        fmr_pkg::PH_PAYLOAD: begin
          pos_nxt         = pos_inc;
          sum_nxt         = sum_add;
          left_nxt        = left_r - fmr_pkg::LEN_W'(1);
          if (left_nxt == '0) phase_nxt = fmr_pkg::PH_SUM_HI;
          res_vld         = 1'b1;
          res.result_kind = fmr_pkg::RES_PAYLOAD;
          res.data        = in_rx_byte;
        end
        fmr_pkg::PH_SUM_HI: begin
          if (sum_r[15:8] != in_rx_byte) begin
            good_nxt  = 1'b0;
            phase_nxt = fmr_pkg::PH_WAIT;
          end else begin
            phase_nxt = fmr_pkg::PH_SUM_LO;
          end
        end
        fmr_pkg::PH_SUM_LO: begin
          good_nxt  = (sum_r[7:0] == in_rx_byte);
          phase_nxt = fmr_pkg::PH_WAIT;
        end
        fmr_pkg::PH_WAIT: begin
        end
        default: begin
          // idle and unused codes: length byte
          reply_seq_nxt = exp_seq_r;
          good_nxt      = 1'b0;
          if (too_long) begin
            sum_nxt       = '0;
            pos_nxt       = '0;
            frame_len_nxt = '0;
            phase_nxt     = fmr_pkg::PH_WAIT;
          end else begin
            sum_nxt       = fmr_pkg::SUM_W'(in_rx_byte);
            pos_nxt       = fmr_pkg::POS_W'(1);
            frame_len_nxt = in_rx_byte[5:0];
            left_nxt      = in_rx_byte[5:0];
            phase_nxt     = fmr_pkg::PH_SEQ;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= fmr_pkg::PH_IDLE;
      limit_r     <= fmr_pkg::LEN_W'(fmr_pkg::MAX_PAYLOAD);
      exp_seq_r   <= '0;
      reply_seq_r <= '0;
      sum_r       <= '0;
      pos_r       <= '0;
      frame_len_r <= '0;
      left_r      <= '0;
      good_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;
      if (in_xfer) begin
        phase_r     <= phase_nxt;
        exp_seq_r   <= exp_seq_nxt;
        reply_seq_r <= reply_seq_nxt;
        sum_r       <= sum_nxt;
        pos_r       <= pos_nxt;
        frame_len_r <= frame_len_nxt;
        left_r      <= left_nxt;
        good_r      <= good_nxt;
      end
    end
  end

  // output register plus skid; skid only fills when the output is stalled
  assign out_open = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_open) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_xfer && res_vld;
      end
    end else if (in_xfer && res_vld) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (in_xfer && res_vld) out_r <= res;
    end else if (in_xfer && res_vld) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_r.result_kind;
  assign out_data         = out_r.data;
  assign out_accepted     = out_r.accepted;
  assign out_frame_length = out_r.frame_length;

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Testbench for framed_message_receiver_top: random framed traffic, stalls on both sides and
// buffer_limit changes between phases, checked against an in-bench frame parser model.
// Depends on fmr_pkg and framed_message_receiver_top.
`timescale 1ns / 1ps

module testbench;
  import fmr_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 185;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] value;
  } line_item_t;

  typedef enum {FR_GOOD, FR_TRAILER, FR_BADSUM, FR_CUT} frame_form_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_kind = KIND_BYTE;
  logic [BYTE_W-1:0]   in_rx_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_result_kind;
  logic [BYTE_W-1:0]   out_data;
  logic                out_accepted;
  logic [LEN_W-1:0]    out_frame_length;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LEN_W-1:0]    cfg_data = '0;

  framed_message_receiver_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_data         (out_data),
    .out_accepted     (out_accepted),
    .out_frame_length (out_frame_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  line_item_t line_q[$];
  result_t    due_results[$];
  int         items_queued = 0;
  int         items_taken = 0;
  int         err_count = 0;
  int         lim = MAX_PAYLOAD;
  int         tx_seq = 0;
  bit         hold_req = 1'b0;
  int         limit_plan[7] = '{63, 0, 21, 42, 63, 1, 0};

  // Receiver model state
  phase_t            ln_phase = PH_IDLE;
  logic [SEQ_W-1:0]  ln_seq = '0;
  logic [SEQ_W-1:0]  ln_reply_seq = '0;
  logic [SUM_W-1:0]  ln_sum = '0;
  logic [POS_W-1:0]  ln_pos = '0;
  logic [LEN_W-1:0]  ln_len = '0;
  logic [LEN_W-1:0]  ln_left = '0;
  logic              ln_good = 1'b0;
  logic [LEN_W-1:0]  ln_limit = LEN_W'(MAX_PAYLOAD);

  function automatic void sum_in(input logic [BYTE_W-1:0] b);
    ln_pos = ln_pos + 1'b1;
    ln_sum = ln_sum + ln_pos * b;
  endfunction

  task automatic frame_step(input logic kind, input logic [BYTE_W-1:0] b,
                            output bit has, output result_t r);
    r = '0;
    has = 1'b0;
    if (kind == KIND_TIMEOUT) begin
      if (ln_phase == PH_IDLE) return;
      if (ln_phase != PH_WAIT) begin
        ln_good = 1'b0;
        ln_phase = PH_WAIT;
        return;
      end
      has = 1'b1;
      r.result_kind = RES_REPLY;
      if (ln_good) begin
        r.data = {REPLY_ACK, ln_reply_seq};
        r.accepted = 1'b1;
        r.frame_length = ln_len;
        ln_seq = ln_seq + 1'b1;
      end else begin
        r.data = {REPLY_NACK, ln_reply_seq};
      end
      ln_phase = PH_IDLE;
      ln_good = 1'b0;
      return;
    end
    case (ln_phase)
      PH_IDLE: begin
        ln_reply_seq = ln_seq;
        ln_sum = '0;
        ln_pos = '0;
        ln_good = 1'b0;
        if (b > MAX_PAYLOAD || b > ln_limit) begin
          ln_len = '0;
          ln_phase = PH_WAIT;
        end else begin
          ln_len = b[LEN_W-1:0];
          ln_left = b[LEN_W-1:0];
          sum_in(b);
          ln_phase = PH_SEQ;
        end
      end
      PH_SEQ: begin
        if (b != {2'b00, ln_seq}) begin
          if (b[7:6] == 2'b00) ln_seq = b[SEQ_W-1:0];
          ln_good = 1'b0;
          ln_phase = PH_WAIT;
        end else begin
          sum_in(b);
          ln_phase = (ln_left == 0) ? PH_SUM_HI : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_in(b);
        ln_left = ln_left - 1'b1;
        if (ln_left == 0) ln_phase = PH_SUM_HI;
        has = 1'b1;
        r.result_kind = RES_PAYLOAD;
        r.data = b;
      end
      PH_SUM_HI: begin
        if (ln_sum[15:8] != b) begin
          ln_good = 1'b0;
          ln_phase = PH_WAIT;
        end else begin
          ln_phase = PH_SUM_LO;
        end
      end
      PH_SUM_LO: begin
        if (ln_sum[7:0] != b) begin
          ln_good = 1'b0;
        end else begin
          ln_good = 1'b1;
        end
        ln_phase = PH_WAIT;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  function automatic int rand_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  // Sender
  int gap_left = 0;
  int tx_mode_cnt = 0;
  bit tx_burst = 1'b0;

  always @(posedge clk) begin : driver
    line_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (line_q.size() != 0) begin
          it = line_q.pop_front();
          in_kind <= it.kind;
          in_rx_byte <= it.value;
          in_valid <= 1'b1;
          gap_left = (tx_burst || $urandom_range(0, 1)) ? 0 : rand_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      tx_mode_cnt++;
      if (tx_mode_cnt % 128 == 0) tx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  // Receiver side: checks results, predicts on each input transfer, drives stall
  int stall_left = 0;
  int rx_mode_cnt = 0;
  bit rx_free = 1'b0;
  bit hold_seen = 1'b0;

  always @(posedge clk) begin : monitor
    result_t want;
    result_t pred;
    bit      has;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      ln_phase = PH_IDLE;
      ln_seq = '0;
      ln_reply_seq = '0;
      ln_sum = '0;
      ln_pos = '0;
      ln_len = '0;
      ln_left = '0;
      ln_good = 1'b0;
      ln_limit = LEN_W'(MAX_PAYLOAD);
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: result_kind %0h data %0h", out_result_kind, out_data);
          err_count++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", want.result_kind, out_result_kind);
          check_field("data", want.data, out_data);
          check_field("accepted", want.accepted, out_accepted);
          check_field("frame_length", want.frame_length, out_frame_length);
        end
      end
      if (in_valid && !in_stall) begin
        frame_step(in_kind, in_rx_byte, has, pred);
        if (has) due_results.push_back(pred);
        items_taken++;
      end
      if (cfg_valid && cfg_ready) ln_limit = cfg_data;

      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!rx_free && $urandom_range(0, 2) == 0) stall_left = rand_gap();
      end
      rx_mode_cnt++;
      if (rx_mode_cnt % 128 == 0) rx_free = ($urandom_range(0, 2) == 0);
    end
  end

  int quiet = 0;

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus
  function automatic void push_item(input logic kind, input logic [BYTE_W-1:0] value);
    line_q.push_back('{kind, value});
    items_queued++;
  endfunction

  task automatic queue_frame(input int len, input int seq_byte, input frame_form_t form,
                             input int fill);
    logic [BYTE_W-1:0] bytes[$];
    int                sum;
    int                cut;
    logic [BYTE_W-1:0] flip;
    bytes.push_back(len[7:0]);
    bytes.push_back(seq_byte[7:0]);
    for (int i = 0; i < len; i++) begin
      bytes.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : fill[7:0]);
    end
    sum = 0;
    foreach (bytes[i]) sum += (i + 1) * bytes[i];
    flip = (form == FR_BADSUM) ? 8'($urandom_range(1, 255)) : 8'h00;
    if ($urandom_range(0, 1)) begin
      bytes.push_back(sum[15:8] ^ flip);
      bytes.push_back(sum[7:0]);
    end else begin
      bytes.push_back(sum[15:8]);
      bytes.push_back(sum[7:0] ^ flip);
    end
    if (form == FR_CUT) begin
      cut = $urandom_range(1, bytes.size() - 1);
      while (bytes.size() > cut) void'(bytes.pop_back());
    end
    foreach (bytes[i]) push_item(KIND_BYTE, bytes[i]);
    if (form == FR_TRAILER) begin
      repeat ($urandom_range(1, 3)) push_item(KIND_BYTE, 8'($urandom_range(0, 255)));
    end
    push_item(KIND_TIMEOUT, 8'($urandom_range(0, 255)));
    // a cut frame needs a second timeout to get its nack out
    if (form == FR_CUT) push_item(KIND_TIMEOUT, 8'($urandom_range(0, 255)));
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, (lim < 8) ? lim : 8);
    if (r < 95) return $urandom_range(0, lim);
    return lim;
  endfunction

  task automatic queue_random_frame();
    int r;
    int len;
    int s;
    r = $urandom_range(0, 99);
    len = pick_len();
    if (r < 55) begin
      queue_frame(len, tx_seq, FR_GOOD, -1);
      tx_seq = (tx_seq + 1) % 64;
    end else if (r < 63) begin
      queue_frame(len, tx_seq, FR_TRAILER, -1);
      tx_seq = (tx_seq + 1) % 64;
    end else if (r < 71) begin
      if (lim == MAX_PAYLOAD || $urandom_range(0, 1)) len = $urandom_range(64, 255);
      else len = $urandom_range(lim + 1, MAX_PAYLOAD);
      push_item(KIND_BYTE, len[7:0]);
      repeat ($urandom_range(0, 3)) push_item(KIND_BYTE, 8'($urandom_range(0, 255)));
      push_item(KIND_TIMEOUT, 8'($urandom_range(0, 255)));
    end else if (r < 79) begin
      do begin
        s = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 255);
      end while (s == tx_seq);
      queue_frame(len, s, FR_GOOD, -1);
      if (s < 64) tx_seq = s;
    end else if (r < 87) begin
      queue_frame(len, tx_seq, FR_BADSUM, -1);
    end else if (r < 95) begin
      queue_frame(len, tx_seq, FR_CUT, -1);
    end else begin
      repeat ($urandom_range(1, 12)) begin
        push_item($urandom_range(0, 4) == 0 ? KIND_TIMEOUT : KIND_BYTE,
                  8'($urandom_range(0, 255)));
      end
      push_item(KIND_TIMEOUT, 8'($urandom_range(0, 255)));
      push_item(KIND_TIMEOUT, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (items_taken != items_queued || due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value[LEN_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    lim = value;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // timeout while idle, good empty frame, oversize length, foreign sequences,
    // bad checksum with all-ones payload, zero payload with sequence wrap
    push_item(KIND_TIMEOUT, 8'hff);
    queue_frame(0, 0, FR_GOOD, -1);
    push_item(KIND_BYTE, 8'hff);
    push_item(KIND_TIMEOUT, 8'h00);
    queue_frame(0, 255, FR_GOOD, -1);
    queue_frame(0, 63, FR_GOOD, -1);
    queue_frame(1, 63, FR_BADSUM, 255);
    queue_frame(2, 63, FR_GOOD, 0);
    wait_drained();
    tx_seq = ln_seq;

    limit_plan[6] = $urandom_range(0, MAX_PAYLOAD);
    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      write_limit(limit_plan[ph]);
      tx_seq = ln_seq;
      if (ph == 0) begin
        // receiver holds off while a full-size frame streams in
        hold_req = !hold_req;
        queue_frame(lim, tx_seq, FR_GOOD, -1);
        tx_seq = (tx_seq + 1) % 64;
      end
      start = items_queued;
      while (items_queued - start < PHASE_ITEMS) begin
        repeat ($urandom_range(1, 6)) queue_random_frame();
        wait_drained();
        tx_seq = ln_seq;
      end
    end

    wait_drained();
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/fmr_pkg.sv
hw/rtl/framed_message_receiver_top.sv
verif/testbench.sv
